FILE: rtl/ura_pkg.sv
// ============================================================================
// ura_pkg: shared types and constants for the ultrasonic range averager
// Widths, reset values, register indexes and the sample record that passes
// from the ranging controller to the averaging stage.
// ============================================================================
package ura_pkg;

    // Field and state widths
    localparam int TIMEOUT_W = 16;
    localparam int TRIG_W    = 8;
    localparam int COUNT_W   = 17;
    localparam int DIST_W    = 11;
    localparam int INDEX_W   = 4;
    localparam int REM_W     = 6;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 16;

    // Ranging constants
    localparam int CM_DIVISOR = 58;
    localparam int MAX_DIST   = 1129;

    // Register reset values
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd26100;
    localparam logic [TRIG_W-1:0]    TRIGGER_RESET = 8'd10;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ECHO_TIMEOUT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_WIDTH = 1'd1;

    // One closed sample, or the start of a burst, for the averaging stage
    typedef struct packed {
        logic              burst_start;
        logic              valid;
        logic              last;
        logic [DIST_W-1:0] cm;
    } ura_sample_t;

endpackage

FILE: rtl/ura_if.sv
// ============================================================================
// ura_if: item channels of the ultrasonic range averager
// One channel carries the tick items in, the other the per-tick results out.
// ============================================================================
interface ura_in_if;
    logic valid;
    logic ready;
    logic start_req;
    logic echo_level;

    modport source (output valid, output start_req, output echo_level, input ready);
    modport sink   (input valid, input start_req, input echo_level, output ready);
endinterface

interface ura_out_if;
    logic                       valid;
    logic                       ready;
    logic                       trigger;
    logic                       busy_res;
    logic                       done_res;
    logic [ura_pkg::DIST_W-1:0] distance_cm;

    modport source (output valid, output trigger, output busy_res, output done_res,
                    output distance_cm, input ready);
    modport sink   (input valid, input trigger, input busy_res, input done_res,
                    input distance_cm, output ready);
endinterface

FILE: rtl/ura_ranger.sv
// ============================================================================
// ura_ranger: trigger and echo measurement controller
// Runs the trigger pulse, waits for the echo, counts echo-high ticks and
// keeps the centimetre quotient as a running count, closing one sample per
// measurement.
// ============================================================================
module ura_ranger #(
    parameter int SAMPLES = 10
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic                          start_req,
    input  logic                          echo_level,
    input  logic [ura_pkg::TIMEOUT_W-1:0] echo_timeout,
    input  logic [ura_pkg::TRIG_W-1:0]    trigger_width,
    output ura_pkg::ura_sample_t          sample,
    output logic                          trigger_next,
    output logic                          busy_next
);
    import ura_pkg::*;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_TRIG = 2'd1;
    localparam logic [1:0] PH_WAIT = 2'd2;
    localparam logic [1:0] PH_MEAS = 2'd3;

    localparam logic [INDEX_W-1:0] LAST_INDEX = INDEX_W'(SAMPLES);
    localparam logic [REM_W-1:0]   REM_TOP    = REM_W'(CM_DIVISOR - 1);

    logic [1:0]         phase_reg, phase_next;
    logic [COUNT_W-1:0] tick_count_reg, tick_count_next;
    logic [INDEX_W-1:0] sample_index_reg, sample_index_next;
    logic [DIST_W-1:0]  quot_reg, quot_next;
    logic [REM_W-1:0]   rem_reg, rem_next;

    logic [COUNT_W-1:0] count_inc;
    logic [COUNT_W-1:0] timeout_ext;
    logic [INDEX_W-1:0] index_inc;
    logic               end_sample;
    logic [DIST_W-1:0]  end_dist;

    assign count_inc   = tick_count_reg + COUNT_W'(1);
    assign timeout_ext = {1'b0, echo_timeout};
    assign index_inc   = sample_index_reg + INDEX_W'(1);

    always_comb
    begin
        phase_next        = phase_reg;
        tick_count_next   = tick_count_reg;
        sample_index_next = sample_index_reg;
        quot_next         = quot_reg;
        rem_next          = rem_reg;
        end_sample        = 1'b0;
        end_dist          = '0;
        sample            = '0;

        case (phase_reg)
            PH_IDLE:
            begin
                if (start_req)
                begin
                    sample.burst_start = 1'b1;
                    sample_index_next  = '0;
                    phase_next         = PH_TRIG;
                    tick_count_next    = COUNT_W'(1);
                end
            end
            PH_TRIG:
            begin
                if (tick_count_reg >= {{(COUNT_W-TRIG_W){1'b0}}, trigger_width})
                begin
                    phase_next      = PH_WAIT;
                    tick_count_next = '0;
                end
                else
                begin
                    tick_count_next = count_inc;
                end
            end
            PH_WAIT:
            begin
                if (echo_level)
                begin
                    phase_next      = PH_MEAS;
                    tick_count_next = COUNT_W'(1);
                    quot_next       = '0;
                    rem_next        = REM_W'(1);
                    // A zero timeout rejects the very first high tick.
                    if (echo_timeout == '0)
                    begin
                        end_sample = 1'b1;
                    end
                end
            end
            PH_MEAS:
            begin
                if (echo_level)
                begin
                    tick_count_next = count_inc;
                    if (rem_reg == REM_TOP)
                    begin
                        rem_next  = '0;
                        quot_next = quot_reg + DIST_W'(1);
                    end
                    else
                    begin
                        rem_next = rem_reg + REM_W'(1);
                    end
                    if (count_inc > timeout_ext)
                    begin
                        end_sample = 1'b1;
                    end
                end
                else
                begin
                    // The running quotient is already floor(count / 58).
                    end_sample = 1'b1;
                    end_dist   = quot_reg;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase

        if (end_sample)
        begin
            sample.valid      = 1'b1;
            sample.cm         = end_dist;
            sample_index_next = index_inc;
            if (index_inc >= LAST_INDEX)
            begin
                sample.last     = 1'b1;
                phase_next      = PH_IDLE;
                tick_count_next = '0;
            end
            else
            begin
                phase_next      = PH_TRIG;
                tick_count_next = COUNT_W'(1);
            end
        end
    end

    assign trigger_next = (phase_next == PH_TRIG);

    // The burst counts as busy in every active phase and on its done tick.
    assign busy_next = (phase_next != PH_IDLE) || sample.last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            tick_count_reg   <= '0;
            sample_index_reg <= '0;
            quot_reg         <= '0;
            rem_reg          <= '0;
        end
        else if (step)
        begin
            phase_reg        <= phase_next;
            tick_count_reg   <= tick_count_next;
            sample_index_reg <= sample_index_next;
            quot_reg         <= quot_next;
            rem_reg          <= rem_next;
        end
    end

    // The remainder counter never reaches the divisor.
    assert property (@(posedge clk) disable iff (!rst_n) rem_reg <= REM_TOP)
        else $error("centimetre remainder out of range");

    // While counting, quotient and remainder together equal the tick count.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_MEAS) |->
        ((32'(quot_reg) * CM_DIVISOR + 32'(rem_reg)) == 32'(tick_count_reg)))
        else $error("running quotient disagrees with tick count");

    // An idle controller holds a cleared tick count.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_IDLE) |-> (tick_count_reg == '0))
        else $error("tick count not cleared in idle");

endmodule

FILE: rtl/ura_average.sv
// ============================================================================
// ura_average: sample accumulator and mean
// Sums the samples of a burst and forms the floor mean with a constant
// reciprocal multiply when the last sample closes.
// ============================================================================
module ura_average #(
    parameter int SAMPLES = 10
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       step,
    input  ura_pkg::ura_sample_t       sample,
    output logic [ura_pkg::DIST_W-1:0] last_distance_next
);
    import ura_pkg::*;

    localparam int SUM_W   = $clog2(MAX_DIST * SAMPLES + 1);
    // Reciprocal shift: the product error stays below one for every sum.
    localparam int SHIFT   = SUM_W + 4;
    localparam logic [SHIFT:0] RECIP = (SHIFT+1)'((2**SHIFT + SAMPLES - 1) / SAMPLES);
    localparam int PROD_W  = SUM_W + SHIFT + 1;

    logic [SUM_W-1:0]  distance_sum_reg, distance_sum_next;
    logic [DIST_W-1:0] last_distance_reg;
    logic [SUM_W-1:0]  sum_add;
    logic [PROD_W-1:0] mean_prod;

    assign sum_add   = distance_sum_reg + SUM_W'(sample.cm);
    assign mean_prod = PROD_W'(sum_add) * PROD_W'(RECIP);

    always_comb
    begin
        distance_sum_next  = distance_sum_reg;
        last_distance_next = last_distance_reg;
        if (sample.burst_start)
        begin
            distance_sum_next = '0;
        end
        if (sample.valid)
        begin
            distance_sum_next = sum_add;
            if (sample.last)
            begin
                last_distance_next = mean_prod[SHIFT +: DIST_W];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            distance_sum_reg  <= '0;
            last_distance_reg <= '0;
        end
        else if (step)
        begin
            distance_sum_reg  <= distance_sum_next;
            last_distance_reg <= last_distance_next;
        end
    end

endmodule

FILE: rtl/ultrasonic_range_averager.sv
// ============================================================================
// ultrasonic_range_averager: averaged ultrasonic ranging controller
// Top level with configuration registers, ranging controller, averager and
// result register.
// ============================================================================
// Each item on the tick channel stands for one microsecond of time and
// carries a start request and the sampled echo level; every item yields
// exactly one result item with the trigger level to drive, the busy flag, a
// one-tick done flag and the averaged distance in centimetres. A start while
// idle runs a burst of SAMPLES measurements: a trigger pulse of
// trigger_width ticks, an unbounded wait for the echo, then counting of
// echo-high ticks. A sample whose echo lasts longer than echo_timeout ticks
// counts as zero, otherwise it is the tick count divided by 58. When the
// last sample closes, the floor mean is shown with done, and distance_cm
// keeps that value until the next mean. Starts during a burst, and on the
// done tick, are ignored. The state registers of the controller and
// averager are updated once per accepted item, and a new item is accepted
// in every cycle in which the result register is empty or its item is being
// taken. The user must write configuration through cfg_wr_en, cfg_index and
// cfg_data only while the block is idle; the block does not enforce this.
module ultrasonic_range_averager #(
    parameter int SAMPLES = 10
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [ura_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ura_pkg::CFG_DAT_W-1:0] cfg_data,
    ura_in_if.sink                        tick,
    ura_out_if.source                     result
);
    import ura_pkg::*;

    logic [TIMEOUT_W-1:0] echo_timeout_reg;
    logic [TRIG_W-1:0]    trigger_width_reg;

    logic                 step;
    ura_sample_t          sample;
    logic                 trigger_next;
    logic                 busy_next;
    logic [DIST_W-1:0]    last_distance_next;

    logic                 valid_reg;
    logic                 trigger_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [DIST_W-1:0]    distance_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            echo_timeout_reg  <= TIMEOUT_RESET;
            trigger_width_reg <= TRIGGER_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_ECHO_TIMEOUT:  echo_timeout_reg  <= cfg_data[TIMEOUT_W-1:0];
                CFG_TRIGGER_WIDTH: trigger_width_reg <= cfg_data[TRIG_W-1:0];
                default:           echo_timeout_reg  <= echo_timeout_reg;
            endcase
        end
    end

    // The result register frees itself in the same cycle that it is read,
    // so items flow one per cycle while the sink keeps up.
    assign tick.ready = !valid_reg || result.ready;
    assign step       = tick.valid && tick.ready;

    ura_ranger #(
        .SAMPLES (SAMPLES)
    ) u_ranger (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .start_req     (tick.start_req),
        .echo_level    (tick.echo_level),
        .echo_timeout  (echo_timeout_reg),
        .trigger_width (trigger_width_reg),
        .sample        (sample),
        .trigger_next  (trigger_next),
        .busy_next     (busy_next)
    );

    ura_average #(
        .SAMPLES (SAMPLES)
    ) u_average (
        .clk                (clk),
        .rst_n              (rst_n),
        .step               (step),
        .sample             (sample),
        .last_distance_next (last_distance_next)
    );

    // Result register. Busy follows the new state and is also high on the
    // done tick, when the controller has already gone back to idle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (step)
        begin
            valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            trigger_reg  <= trigger_next;
            busy_reg     <= busy_next;
            done_reg     <= sample.last;
            distance_reg <= last_distance_next;
        end
    end

    assign result.valid       = valid_reg;
    assign result.trigger     = trigger_reg;
    assign result.busy_res    = busy_reg;
    assign result.done_res    = done_reg;
    assign result.distance_cm = distance_reg;

    // A done item always reports busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && done_reg) |-> busy_reg)
        else $error("done result without busy");

    // An empty result register never stalls the tick channel.
    assert property (@(posedge clk) disable iff (!rst_n)
        !valid_reg |-> tick.ready)
        else $error("tick channel stalled with empty result register");

    // A waiting result holds while the sink stalls.
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !result.ready) |=> (valid_reg && $stable(done_reg)
                                          && $stable(distance_reg)))
        else $error("stalled result changed");

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_top: self-checking bench for the ultrasonic range averager
// Drives one tick item per handshake into the block and compares every
// result item, field by field, with a cycle-free model of the ranging and
// averaging behaviour kept inside the bench. A short table of hand-checked
// ticks opens the run. Randomised bursts follow under several register
// settings, the smallest settings and the widest echo limit among them.
// Both channels idle and stall at random.
// ============================================================================
module tb_top;

    import ura_pkg::*;

    localparam int NUM_SAMPLES = 10;
    localparam int CYCLE_LIMIT = 200_000;
    localparam int ITEM_GOAL   = 1900;

    // Phases of the ranging sequence as the bench models them.
    typedef enum logic [1:0] {
        RANGE_IDLE,
        RANGE_TRIG,
        RANGE_WAIT,
        RANGE_MEAS
    } range_phase_e;

    // One result item as seen on the result channel.
    typedef struct packed {
        logic              trigger;
        logic              busy;
        logic              done;
        logic [DIST_W-1:0] cm;
    } tick_res_t;

    // One row of the opening table: a tick, how often it is sent, and, where
    // the answer is obvious, the result typed in by hand.
    typedef struct packed {
        logic       start;
        logic       echo;
        logic [7:0] reps;
        logic       typed;
        tick_res_t  res;
    } tick_row_t;

    localparam tick_res_t QUIET_RES  = '{1'b0, 1'b0, 1'b0, 11'd0};
    localparam tick_res_t PULSE_RES  = '{1'b1, 1'b1, 1'b0, 11'd0};
    localparam tick_res_t LISTEN_RES = '{1'b0, 1'b1, 1'b0, 11'd0};

    // Opening table, run with the reset settings (a ten-tick pulse). The
    // burst it starts is left open and is carried on by the random part.
    localparam int OPENING_ROWS = 9;
    localparam tick_row_t OPENING [OPENING_ROWS] = '{
        '{1'b0, 1'b0, 8'd1, 1'b1, QUIET_RES},  // idle after reset
        '{1'b0, 1'b1, 8'd1, 1'b1, QUIET_RES},  // echo is ignored while idle
        '{1'b1, 1'b1, 8'd1, 1'b1, PULSE_RES},  // start tick is the first pulse tick
        '{1'b1, 1'b0, 8'd4, 1'b1, PULSE_RES},  // start while busy is ignored
        '{1'b0, 1'b1, 8'd5, 1'b1, PULSE_RES},  // rest of the pulse, echo ignored
        '{1'b1, 1'b1, 8'd1, 1'b1, LISTEN_RES}, // pulse ends, echo still ignored
        '{1'b0, 1'b0, 8'd2, 1'b0, QUIET_RES},  // waiting for the echo to rise
        '{1'b0, 1'b1, 8'd3, 1'b0, QUIET_RES},  // echo high ticks are counted
        '{1'b1, 1'b0, 8'd1, 1'b0, QUIET_RES}   // echo falls: sample closes
    };

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;

    ura_in_if  tick_if ();
    ura_out_if result_if ();

    ultrasonic_range_averager #(
        .SAMPLES (NUM_SAMPLES)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .tick      (tick_if),
        .result    (result_if)
    );

    // Model state and its copy of the registers.
    range_phase_e         rng_phase;
    logic [COUNT_W-1:0]   tick_count;
    logic [INDEX_W-1:0]   sample_idx;
    logic [14:0]          dist_sum;
    logic [DIST_W-1:0]    last_dist;
    logic [TIMEOUT_W-1:0] echo_limit;
    logic [TRIG_W-1:0]    pulse_len;

    tick_res_t pending_ticks[$];

    int  err_count;
    int  items_sent;
    int  cycle_count = 0;
    int  echo_left;    // further ticks the simulated echo stays high
    bit  steady;       // no idling on either side while set

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: a hung handshake must not keep the run alive.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // The result side stalls at random, except in the steady stretch.
    always @(posedge clk)
    begin
        result_if.ready <= steady || ($urandom_range(0, 99) >= 31);
    end

    // Every result item taken is held against the oldest expectation.
    always @(posedge clk)
    begin
        tick_res_t want;
        if (rst_n && result_if.valid && result_if.ready)
        begin
            if (pending_ticks.size() == 0)
            begin
                $error("result item with no expectation pending");
                err_count++;
            end
            else
            begin
                want = pending_ticks.pop_front();
                if (result_if.trigger !== want.trigger)
                begin
                    $error("trigger: expected %0d, got %0d", want.trigger, result_if.trigger);
                    err_count++;
                end
                if (result_if.busy_res !== want.busy)
                begin
                    $error("busy_res: expected %0d, got %0d", want.busy, result_if.busy_res);
                    err_count++;
                end
                if (result_if.done_res !== want.done)
                begin
                    $error("done_res: expected %0d, got %0d", want.done, result_if.done_res);
                    err_count++;
                end
                if (result_if.distance_cm !== want.cm)
                begin
                    $error("distance_cm: expected %0d, got %0d", want.cm,
                           result_if.distance_cm);
                    err_count++;
                end
            end
        end
    end

    // Close the sample in hand with the given distance. The burst is over
    // once the last sample is in; otherwise the next pulse starts at once,
    // on the same tick.
    function automatic logic close_sample(input logic [DIST_W-1:0] cm);
        dist_sum   = dist_sum + cm;
        sample_idx = sample_idx + 1'b1;
        if (sample_idx >= NUM_SAMPLES)
        begin
            last_dist  = DIST_W'(dist_sum / NUM_SAMPLES);
            rng_phase  = RANGE_IDLE;
            tick_count = '0;
            return 1'b1;
        end
        rng_phase  = RANGE_TRIG;
        tick_count = COUNT_W'(1);
        return 1'b0;
    endfunction

    // Advance the model by one tick and give the result it produces.
    task automatic range_step(input logic start, input logic echo, output tick_res_t res);
        logic done;
        done = 1'b0;
        case (rng_phase)
            RANGE_IDLE:
            begin
                if (start)
                begin
                    sample_idx = '0;
                    dist_sum   = '0;
                    rng_phase  = RANGE_TRIG;
                    tick_count = COUNT_W'(1);
                end
            end
            RANGE_TRIG:
            begin
                // The tick that ends the pulse does not look at the echo.
                if (tick_count >= pulse_len)
                begin
                    rng_phase  = RANGE_WAIT;
                    tick_count = '0;
                end
                else
                begin
                    tick_count = tick_count + 1'b1;
                end
            end
            RANGE_WAIT:
            begin
                if (echo)
                begin
                    tick_count = COUNT_W'(1);
                    rng_phase  = RANGE_MEAS;
                    if (tick_count > echo_limit)
                        done = close_sample('0);
                end
            end
            default:
            begin
                if (echo)
                begin
                    // An echo that outlasts the limit closes the sample as zero
                    // while it is still high.
                    tick_count = tick_count + 1'b1;
                    if (tick_count > echo_limit)
                        done = close_sample('0);
                end
                else
                begin
                    done = close_sample(DIST_W'(tick_count / CM_DIVISOR));
                end
            end
        endcase
        res.trigger = (rng_phase == RANGE_TRIG);
        res.busy    = (rng_phase != RANGE_IDLE) || done;
        res.done    = done;
        res.cm      = last_dist;
    endtask

    // Offer one tick item, with random idle cycles ahead of it, and wait for
    // it to be taken. The model moves on only when the block takes the item,
    // so the next tick can be chosen from the phase the block is now in.
    task automatic send_tick(input logic start, input logic echo, input logic typed,
                             input tick_res_t typed_res);
        tick_res_t res;
        while (!steady && ($urandom_range(0, 99) < 31))
        begin
            tick_if.valid <= 1'b0;
            @(posedge clk);
        end
        tick_if.valid      <= 1'b1;
        tick_if.start_req  <= start;
        tick_if.echo_level <= echo;
        do
            @(posedge clk);
        while (!tick_if.ready);
        range_step(start, echo, res);
        pending_ticks.push_back(typed ? typed_res : res);
        items_sent++;
    endtask

    // Length of the next echo pulse. Most are short; some sit right on the
    // echo limit or on a boundary of the 58-tick centimetre step.
    function automatic int pick_echo_len();
        int lo;
        case ($urandom_range(0, 9))
            6, 7:
            begin
                if (echo_limit <= 2000)
                begin
                    lo = (echo_limit > 2) ? echo_limit - 2 : 1;
                    return $urandom_range(lo, echo_limit + 2);
                end
                return $urandom_range(1, 120);
            end
            8:       return $urandom_range(1, 3);
            9:       return CM_DIVISOR * $urandom_range(1, 3) + $urandom_range(0, 2) - 1;
            default: return $urandom_range(1, 60);
        endcase
    endfunction

    // A random tick shaped like a real sensor: while a burst waits, the echo
    // rises at a random tick and stays up for a chosen length. Outside the
    // wait and count phases, once such an echo is over, the echo line is plain noise.
    task automatic random_tick(input bit allow_start);
        logic start;
        logic echo;
        if (echo_left > 0)
        begin
            echo = 1'b1;
            echo_left--;
        end
        else
        begin
            case (rng_phase)
                RANGE_WAIT:
                begin
                    echo = ($urandom_range(0, 3) == 0);
                    if (echo)
                        echo_left = pick_echo_len() - 1;
                end
                RANGE_MEAS: echo = 1'b0;
                default:    echo = ($urandom_range(0, 1) == 1);
            endcase
        end
        if (rng_phase == RANGE_IDLE)
            start = allow_start && ($urandom_range(0, 3) != 0);
        else
            start = ($urandom_range(0, 1) == 1);
        send_tick(start, echo, 1'b0, QUIET_RES);
    endtask

    // Random ticks, then enough further ticks without a start to let the
    // burst in progress run out.
    task automatic run_bursts(input int count);
        repeat (count)
            random_tick(1'b1);
        while (rng_phase != RANGE_IDLE)
            random_tick(1'b0);
    endtask

    // Stop offering ticks and wait until every result has come back.
    task automatic drain();
        tick_if.valid <= 1'b0;
        while (pending_ticks.size() != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
    endtask

    // Write both registers while the block is idle.
    task automatic set_ranging(input logic [TIMEOUT_W-1:0] limit,
                               input logic [TRIG_W-1:0] width);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_ECHO_TIMEOUT;
        cfg_data  <= limit;
        @(posedge clk);
        cfg_index <= CFG_TRIGGER_WIDTH;
        cfg_data  <= {{(CFG_DAT_W-TRIG_W){1'b0}}, width};
        @(posedge clk);
        cfg_wr_en  <= 1'b0;
        echo_limit = limit;
        pulse_len  = width;
    endtask

    initial
    begin
        logic [TIMEOUT_W-1:0] limit;
        logic [TRIG_W-1:0]    width;

        rst_n              = 1'b0;
        cfg_wr_en          = 1'b0;
        cfg_index          = CFG_ECHO_TIMEOUT;
        cfg_data           = '0;
        tick_if.valid      = 1'b0;
        tick_if.start_req  = 1'b0;
        tick_if.echo_level = 1'b0;
        result_if.ready    = 1'b0;
        steady             = 1'b0;
        err_count          = 0;
        items_sent         = 0;
        echo_left          = 0;

        rng_phase  = RANGE_IDLE;
        tick_count = '0;
        sample_idx = '0;
        dist_sum   = '0;
        last_dist  = '0;
        echo_limit = TIMEOUT_RESET;
        pulse_len  = TRIGGER_RESET;

        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Hand-checked opening ticks, under the reset settings.
        for (int r = 0; r < OPENING_ROWS; r++)
            repeat (OPENING[r].reps)
                send_tick(OPENING[r].start, OPENING[r].echo, OPENING[r].typed,
                          OPENING[r].res);

        // Carry on under the reset settings, finishing the open burst.
        run_bursts(60);

        // Shortest pulse and tightest limit: nearly every echo times out,
        // and a timed-out echo is often still high for the next sample.
        set_ranging(16'd1, 8'd1);
        run_bursts(150);

        // Widest echo limit with a short pulse.
        set_ranging(16'hFFFF, 8'd4);
        run_bursts(60);

        // A long stretch with no idling on either side, echoes around the
        // limit.
        steady = 1'b1;
        set_ranging(16'd100, 8'd3);
        run_bursts(150);
        steady = 1'b0;

        // Random settings until enough ticks have gone through.
        while (items_sent < ITEM_GOAL)
        begin
            limit = ($urandom_range(0, 4) == 0) ? TIMEOUT_W'($urandom_range(1, 65535))
                                                : TIMEOUT_W'($urandom_range(1, 400));
            width = TRIG_W'($urandom_range(1, 20));
            set_ranging(limit, width);
            run_bursts(40);
        end

        drain();
        repeat (10)
            @(posedge clk);

        if (pending_ticks.size() != 0)
        begin
            $error("%0d expected result items never arrived", pending_ticks.size());
            err_count++;
        end

        if (err_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
